### rtl/core/ektp_pkg.sv
`default_nettype none

package ektp_pkg;

  // Parser phase, one-hot
  typedef enum logic [5:0] {
    PH_PFX0 = 6'b000001,
    PH_PFX1 = 6'b000010,
    PH_BODY = 6'b000100,
    PH_ESC  = 6'b001000,
    PH_TS   = 6'b010000,
    PH_ERR  = 6'b100000
  } phase_t;

  // Status codes of the final result
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_PREFIX = 3'd1;
  localparam logic [2:0] ST_ESCAPE = 3'd2;
  localparam logic [2:0] ST_NOTERM = 3'd3;
  localparam logic [2:0] ST_TSLEN  = 3'd4;

  // Result kinds
  localparam logic KIND_KEY    = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // Escape bytes
  localparam logic [7:0] BYTE_ESC     = 8'h00;
  localparam logic [7:0] BYTE_END     = 8'h01;
  localparam logic [7:0] BYTE_ESCZERO = 8'hFF;

  // Timestamp length and the saturated "too many" count
  localparam logic [3:0] TS_BYTES = 4'd8;
  localparam logic [3:0] TS_OVER  = 4'd9;

  // Register map: index taken from paddr[2]
  localparam logic REG_WRITE_PREFIX = 1'b0;

  // One result request
  typedef struct packed {
    logic        kind;
    logic [7:0]  key_byte;
    logic [2:0]  status;
    logic [63:0] timestamp;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/escaped_key_timestamp_parser_core.sv
// A byte's result (if any) is registered in out_r, or in the skid entry while out_r is held, and shows on out_*.
// Throughput: one byte per cycle while the skid entry is empty; the whole phase update is one registered step.
// A register plus a skid entry on the result side keep in_ready high while the skid entry is empty.
// Reset (rst_n low, synchronous): parser back to the first prefix byte, prefix cleared
// to zero, no result pending.
`default_nettype none

module escaped_key_timestamp_parser_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  // result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_kind,
  output logic [7:0]       out_key_byte,
  output logic [2:0]       out_status,
  output logic [63:0]      out_timestamp,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  ektp_pkg::phase_t  phase_r, phase_nxt, phase_upd;
  logic [3:0]        ts_count_r, ts_count_nxt, ts_count_upd;
  logic [63:0]       ts_accum_r, ts_accum_nxt, ts_accum_upd;
  logic [2:0]        error_code_r, error_code_nxt, error_code_upd;
  logic [15:0]       prefix_r;

  ektp_pkg::result_t res;
  logic              emit;
  logic              accept;
  logic              out_valid_r, skid_valid_r;
  ektp_pkg::result_t out_r, skid_r;

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == ektp_pkg::REG_WRITE_PREFIX) ? {16'b0, prefix_r} : 32'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= 16'b0;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == ektp_pkg::REG_WRITE_PREFIX) begin
      prefix_r <= pwdata[15:0];
    end
  end

  assign accept = in_valid && in_ready;

  // Phase update for one byte
  always_comb begin
    phase_upd      = phase_r;
    ts_count_upd   = ts_count_r;
    ts_accum_upd   = ts_accum_r;
    error_code_upd = error_code_r;
    emit           = 1'b0;
    res            = '0;
    case (phase_r)
      ektp_pkg::PH_PFX0: begin
        if (in_byte != prefix_r[15:8]) begin
          phase_upd      = ektp_pkg::PH_ERR;
          error_code_upd = ektp_pkg::ST_PREFIX;
        end else begin
          phase_upd = ektp_pkg::PH_PFX1;
        end
      end
      ektp_pkg::PH_PFX1: begin
        if (in_byte != prefix_r[7:0]) begin
          phase_upd      = ektp_pkg::PH_ERR;
          error_code_upd = ektp_pkg::ST_PREFIX;
        end else begin
          phase_upd = ektp_pkg::PH_BODY;
        end
      end
      ektp_pkg::PH_BODY: begin
        if (in_byte == ektp_pkg::BYTE_ESC) begin
          phase_upd = ektp_pkg::PH_ESC;
        end else begin
          emit         = 1'b1;
          res.key_byte = in_byte;
        end
      end
      ektp_pkg::PH_ESC: begin
        if (in_byte == ektp_pkg::BYTE_END) begin
          phase_upd    = ektp_pkg::PH_TS;
          ts_count_upd = 4'd0;
          ts_accum_upd = 64'd0;
        end else if (in_byte == ektp_pkg::BYTE_ESCZERO) begin
          emit      = 1'b1;
          phase_upd = ektp_pkg::PH_BODY;
        end else begin
          phase_upd      = ektp_pkg::PH_ERR;
          error_code_upd = ektp_pkg::ST_ESCAPE;
        end
      end
      ektp_pkg::PH_TS: begin
        if (ts_count_r < ektp_pkg::TS_BYTES) begin
          ts_accum_upd = {ts_accum_r[55:0], in_byte};
          ts_count_upd = ts_count_r + 4'd1;
        end else begin
          ts_count_upd = ektp_pkg::TS_OVER;
        end
      end
      ektp_pkg::PH_ERR: begin
      end
      default: begin
        phase_upd      = ektp_pkg::PH_ERR;
        error_code_upd = ektp_pkg::ST_PREFIX;
      end
    endcase

    // Final byte: status result replaces any key byte
    if (in_last) begin
      emit         = 1'b1;
      res.kind     = ektp_pkg::KIND_STATUS;
      res.key_byte = 8'd0;
      case (phase_upd)
        ektp_pkg::PH_PFX0, ektp_pkg::PH_PFX1: res.status = ektp_pkg::ST_PREFIX;
        ektp_pkg::PH_BODY, ektp_pkg::PH_ESC:  res.status = ektp_pkg::ST_NOTERM;
        ektp_pkg::PH_TS: begin
          if (ts_count_upd == ektp_pkg::TS_BYTES) begin
            res.status    = ektp_pkg::ST_OK;
            res.timestamp = ~ts_accum_upd;
          end else begin
            res.status = ektp_pkg::ST_TSLEN;
          end
        end
        default: res.status = error_code_upd;
      endcase
    end
  end

  // Restart after the final byte
  always_comb begin
    phase_nxt      = phase_upd;
    ts_count_nxt   = ts_count_upd;
    ts_accum_nxt   = ts_accum_upd;
    error_code_nxt = error_code_upd;
    if (in_last) begin
      phase_nxt      = ektp_pkg::PH_PFX0;
      ts_count_nxt   = 4'd0;
      ts_accum_nxt   = 64'd0;
      error_code_nxt = ektp_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= ektp_pkg::PH_PFX0;
      ts_count_r   <= 4'd0;
      ts_accum_r   <= 64'd0;
      error_code_r <= ektp_pkg::ST_OK;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      ts_count_r   <= ts_count_nxt;
      ts_accum_r   <= ts_accum_nxt;
      error_code_r <= error_code_nxt;
    end
  end

  // Result register with one skid entry
  assign in_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) begin
        out_valid_r  <= skid_valid_r || (accept && emit);
        skid_valid_r <= 1'b0;
      end else if (accept && emit) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= out_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_ready) begin
      if (skid_valid_r) begin
        out_r <= skid_r;
      end else if (accept && emit) begin
        out_r <= res;
      end
    end else if (accept && emit) begin
      if (out_valid_r) begin
        skid_r <= res;
      end else begin
        out_r <= res;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_r.kind;
  assign out_key_byte  = out_r.key_byte;
  assign out_status    = out_r.status;
  assign out_timestamp = out_r.timestamp;

  // Checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without a result in the output register");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> out_valid_r)
    else $error("final byte produced no status result");

  a_last_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last) |=> (phase_r == ektp_pkg::PH_PFX0 && error_code_r == ektp_pkg::ST_OK))
    else $error("parser did not restart after the final byte");

  a_key_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind == ektp_pkg::KIND_KEY) |->
      (out_status == ektp_pkg::ST_OK && out_timestamp == 64'd0))
    else $error("key byte result carries status or timestamp");

endmodule

`default_nettype wire
